// File: hdl/dgcc_pkg.sv
package dgcc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES = 256;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MARK_NEW  = 2'd0,
    MARK_PATH = 2'd1,
    MARK_DONE = 2'd2
  } mark_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_WR,
    ST_SCAN,
    ST_START,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_EDGE_CHK,
    ST_VISIT,
    ST_RESULT
  } state_t;

endpackage

// File: hdl/dgcc_ram.sv
module dgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/directed_graph_cycle_check.sv
// directed graph cycle check
// input channel: one word per valid/ready handshake carrying action,
// src_vertex and dst_vertex. add stores an edge at the head of the source
// vertex's adjacency list, clear empties the graph and drop flags, check
// runs a depth-first search from each unvisited vertex below vertex_count until a cycle is found.
// output channel: one word per check with has_cycle and the two sticky
// drop flags, held in an output register; add, clear and unused codes
// give no word.
// a stored add keeps in_ready low while its list head is written (the head
// is read at the accepting edge and written the cycle after); a dropped add,
// clear or unused code goes straight back to idle. a check steps through
// each start vertex tested, each edge followed and each vertex finished,
// then loads the result, reading the memories through registered ports.
// one word is processed at a time. a waiting result does not hold off
// adds or clears; a later check holds its result until the register frees.
// reset: all lists empty, no edges, flags clear, vertex_count 64; the block
// is ready at once since list heads and marks carry valid bits.
// the user is to write vertex_count through cfg_we/cfg_data only while the block is idle; it is not enforced.
module directed_graph_cycle_check
  import dgcc_pkg::*;
#(
  parameter int MAX_V = MAX_VERTICES,
  parameter int MAX_E = MAX_EDGES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [6:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic [$clog2(MAX_V)-1:0] src_vertex,
  input  logic [$clog2(MAX_V)-1:0] dst_vertex,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     has_cycle,
  output logic                     edges_dropped_full,
  output logic                     edges_dropped_range
);

  localparam int VW = $clog2(MAX_V);
  localparam int EW = $clog2(MAX_E);
  localparam int LW = $clog2(MAX_E + 1);
  localparam int CW = $clog2(MAX_V + 1);
  localparam int SW = VW + LW;

  state_t state, state_next;

  logic [6:0]       vertex_count;
  logic [CW-1:0]    n_active;
  logic [LW-1:0]    edge_total;
  logic             flag_full, flag_range;
  logic [MAX_V-1:0] head_valid;
  logic [MAX_V-1:0] mark_valid;
  logic             head_rd_valid;
  logic             mark_rd_valid;
  logic [VW-1:0]    cur_src, cur_dst;
  logic [CW-1:0]    scan_idx;
  logic [CW-1:0]    depth;
  logic [CW-1:0]    depth_m1;
  logic [VW-1:0]    top_v;
  logic [VW-1:0]    w_v;
  logic             cycle_found;
  logic             in_fire;
  logic             src_bad, dst_bad, add_ok;
  logic             res_load;
  logic [LW-1:0]    head_val;
  logic [1:0]       mark_val;
  logic [VW-1:0]    stk_v;
  logic [LW-1:0]    stk_e;
  logic [VW-1:0]    edge_dst;
  logic [LW-1:0]    edge_link;

  // memories
  logic          head_we;
  logic [VW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rdata;
  logic          edge_we;
  logic [EW-1:0] edge_waddr, edge_raddr;
  logic [SW-1:0] edge_wdata, edge_rdata;
  logic          mark_we;
  logic [VW-1:0] mark_waddr, mark_raddr;
  logic [1:0]    mark_wdata, mark_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  dgcc_ram #(.WIDTH(LW), .DEPTH(MAX_V)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  dgcc_ram #(.WIDTH(SW), .DEPTH(MAX_E)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata));
  dgcc_ram #(.WIDTH(2), .DEPTH(MAX_V)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata));
  dgcc_ram #(.WIDTH(SW), .DEPTH(MAX_V)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  assign n_active = (32'(vertex_count) > 32'(MAX_V)) ? CW'(MAX_V) : CW'(vertex_count);
  assign head_val = head_rd_valid ? head_rdata : LW'(MAX_E);
  // unwritten marks read as new
  assign mark_val = mark_rd_valid ? mark_rdata : MARK_NEW;
  assign depth_m1 = depth - CW'(1);

  assign stk_v = stk_rdata[SW-1:LW];
  assign stk_e = stk_rdata[LW-1:0];
  assign edge_dst = edge_rdata[SW-1:LW];
  assign edge_link = edge_rdata[LW-1:0];

  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign res_load = (state == ST_RESULT) && (!out_valid || out_ready);

  assign src_bad = (CW'(src_vertex) >= n_active);
  assign dst_bad = (CW'(dst_vertex) >= n_active);
  assign add_ok = !src_bad && !dst_bad && (edge_total < LW'(MAX_E));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (action_t'(action))
            ACT_ADD: begin
              if (add_ok) begin
                state_next = ST_HEAD_WR;
              end
            end
            ACT_CHECK: state_next = ST_SCAN;
            ACT_CLEAR: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_HEAD_WR: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_idx >= n_active) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (mark_val == MARK_NEW) begin
          state_next = ST_TOP_RD;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_TOP_RD: begin
        if (depth == '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_TOP_CHK;
        end
      end
      ST_TOP_CHK: begin
        if (stk_e >= LW'(MAX_E)) begin
          state_next = ST_TOP_RD;
        end else begin
          state_next = ST_EDGE_CHK;
        end
      end
      ST_EDGE_CHK: state_next = ST_VISIT;
      ST_VISIT: begin
        if (mark_val == MARK_PATH) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_TOP_RD;
        end
      end
      ST_RESULT: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    head_we = 1'b0;
    head_waddr = cur_src;
    head_wdata = edge_total;
    head_raddr = src_vertex;
    edge_we = 1'b0;
    edge_waddr = edge_total[EW-1:0];
    edge_wdata = {cur_dst, head_val};
    edge_raddr = stk_e[EW-1:0];
    mark_we = 1'b0;
    mark_waddr = top_v;
    mark_wdata = MARK_DONE;
    mark_raddr = scan_idx[VW-1:0];
    stk_we = 1'b0;
    stk_waddr = depth[VW-1:0];
    stk_wdata = {w_v, head_val};
    stk_raddr = depth_m1[VW-1:0];
    unique case (state)
      ST_HEAD_WR: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      ST_SCAN: begin
        mark_raddr = scan_idx[VW-1:0];
        head_raddr = scan_idx[VW-1:0];
      end
      ST_START: begin
        if (mark_val == MARK_NEW) begin
          stk_we = 1'b1;
          stk_wdata = {scan_idx[VW-1:0], head_val};
          mark_we = 1'b1;
          mark_waddr = scan_idx[VW-1:0];
          mark_wdata = MARK_PATH;
        end
      end
      ST_TOP_CHK: begin
        if (stk_e >= LW'(MAX_E)) begin
          mark_we = 1'b1;
          mark_waddr = stk_v;
          mark_wdata = MARK_DONE;
        end
      end
      ST_EDGE_CHK: begin
        stk_we = 1'b1;
        stk_waddr = depth_m1[VW-1:0];
        stk_wdata = {top_v, edge_link};
        mark_raddr = edge_dst;
        head_raddr = edge_dst;
      end
      ST_VISIT: begin
        if (mark_val == MARK_NEW) begin
          stk_we = 1'b1;
          mark_we = 1'b1;
          mark_waddr = w_v;
          mark_wdata = MARK_PATH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vertex_count <= 7'd64;
      edge_total <= '0;
      flag_full <= 1'b0;
      flag_range <= 1'b0;
      head_valid <= '0;
      mark_valid <= '0;
      head_rd_valid <= 1'b0;
      mark_rd_valid <= 1'b0;
      depth <= '0;
      scan_idx <= '0;
      cycle_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      head_rd_valid <= head_valid[head_raddr];
      mark_rd_valid <= mark_valid[mark_raddr];
      if (head_we) begin
        head_valid[head_waddr] <= 1'b1;
        edge_total <= edge_total + LW'(1);
      end
      if (mark_we) begin
        mark_valid[mark_waddr] <= 1'b1;
      end
      if (in_fire) begin
        unique case (action_t'(action))
          ACT_ADD: begin
            if (src_bad || dst_bad) begin
              flag_range <= 1'b1;
            end else if (edge_total >= LW'(MAX_E)) begin
              flag_full <= 1'b1;
            end
          end
          ACT_CHECK: begin
            mark_valid <= '0;
            scan_idx <= '0;
            depth <= '0;
            cycle_found <= 1'b0;
          end
          ACT_CLEAR: begin
            head_valid <= '0;
            edge_total <= '0;
            flag_full <= 1'b0;
            flag_range <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state)
        ST_START: begin
          scan_idx <= scan_idx + CW'(1);
          if (mark_val == MARK_NEW) begin
            depth <= depth + CW'(1);
          end
        end
        ST_TOP_CHK: begin
          if (stk_e >= LW'(MAX_E)) begin
            depth <= depth_m1;
          end
        end
        ST_VISIT: begin
          if (mark_val == MARK_PATH) begin
            cycle_found <= 1'b1;
          end else if (mark_val == MARK_NEW) begin
            depth <= depth + CW'(1);
          end
        end
        default: ;
      endcase
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_src <= src_vertex;
      cur_dst <= dst_vertex;
    end
    if (state == ST_TOP_CHK) begin
      top_v <= stk_v;
    end
    if (state == ST_EDGE_CHK) begin
      w_v <= edge_dst;
    end
    if (res_load) begin
      has_cycle <= cycle_found;
      edges_dropped_full <= flag_full;
      edges_dropped_range <= flag_range;
    end
  end

endmodule

// File: tb/dgcc_result_checker.sv
`timescale 1ns / 1ps

module dgcc_result_checker
  import dgcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] action,
  input  logic [5:0] src_vertex,
  input  logic [5:0] dst_vertex,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       has_cycle,
  input  logic       edges_dropped_full,
  input  logic       edges_dropped_range,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic cyc;
    logic full;
    logic range_drop;
  } verdict_t;

  verdict_t verdict_q[$];
  int       list_first[MAX_VERTICES];
  int       edge_dst[MAX_EDGES];
  int       edge_next[MAX_EDGES];
  int       stored_edges;
  logic     drop_full;
  logic     drop_range;
  int       vcount;

  assign pending = verdict_q.size();

  function automatic int live_vertices();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
  endfunction

  function automatic logic graph_cyclic();
    mark_t mark[MAX_VERTICES];
    int    stk_v[MAX_VERTICES];
    int    stk_e[MAX_VERTICES];
    int    depth;
    int    e;
    int    w;
    for (int i = 0; i < MAX_VERTICES; i++) mark[i] = MARK_NEW;
    for (int i = 0; i < live_vertices(); i++) begin
      if (mark[i] == MARK_NEW) begin
        mark[i] = MARK_PATH;
        stk_v[0] = i;
        stk_e[0] = list_first[i];
        depth = 1;
        while (depth > 0) begin
          e = stk_e[depth-1];
          if (e >= MAX_EDGES) begin
            mark[stk_v[depth-1]] = MARK_DONE;
            depth--;
          end else begin
            w = edge_dst[e];
            stk_e[depth-1] = edge_next[e];
            if (mark[w] == MARK_PATH) return 1'b1;
            if (mark[w] == MARK_NEW && depth < MAX_VERTICES) begin
              mark[w] = MARK_PATH;
              stk_v[depth] = w;
              stk_e[depth] = list_first[w];
              depth++;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic empty_graph();
    for (int i = 0; i < MAX_VERTICES; i++) list_first[i] = MAX_EDGES;
    stored_edges = 0;
    drop_full = 1'b0;
    drop_range = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    vcount = 64;
    empty_graph();
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      vcount = 64;
      empty_graph();
    end else begin
      if (cfg_we) vcount = cfg_data;
      if (in_valid && in_ready) begin
        case (action_t'(action))
          ACT_ADD: begin
            if (src_vertex >= live_vertices() || dst_vertex >= live_vertices())
              drop_range = 1'b1;
            else if (stored_edges >= MAX_EDGES)
              drop_full = 1'b1;
            else begin
              edge_dst[stored_edges] = dst_vertex;
              edge_next[stored_edges] = list_first[src_vertex];
              list_first[src_vertex] = stored_edges;
              stored_edges++;
            end
          end
          ACT_CHECK: begin
            want.cyc = graph_cyclic();
            want.full = drop_full;
            want.range_drop = drop_range;
            verdict_q.push_back(want);
          end
          ACT_CLEAR: empty_graph();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          want = verdict_q.pop_front();
          if (has_cycle !== want.cyc) report("has_cycle", has_cycle, want.cyc);
          if (edges_dropped_full !== want.full)
            report("edges_dropped_full", edges_dropped_full, want.full);
          if (edges_dropped_range !== want.range_drop)
            report("edges_dropped_range", edges_dropped_range, want.range_drop);
        end
      end
    end
  end

endmodule

// File: tb/tb_directed_graph_cycle_check.sv
`timescale 1ns / 1ps

module tb_directed_graph_cycle_check;
  import dgcc_pkg::*;

  localparam int STALL_LIMIT = 40000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = ACT_NONE;
  logic [5:0] src_vertex = '0;
  logic [5:0] dst_vertex = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       has_cycle;
  logic       edges_dropped_full;
  logic       edges_dropped_range;
  int         fail_count;
  int         pending;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         words_sent = 0;
  int         cur_vc = 64;
  int         quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  directed_graph_cycle_check i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (action),
    .src_vertex          (src_vertex),
    .dst_vertex          (dst_vertex),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .has_cycle           (has_cycle),
    .edges_dropped_full  (edges_dropped_full),
    .edges_dropped_range (edges_dropped_range)
  );

  dgcc_result_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (action),
    .src_vertex          (src_vertex),
    .dst_vertex          (dst_vertex),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .has_cycle           (has_cycle),
    .edges_dropped_full  (edges_dropped_full),
    .edges_dropped_range (edges_dropped_range),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input action_t a, input int s, input int d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    src_vertex <= 6'(s);
    dst_vertex <= 6'(d);
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int vc);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= 7'(vc);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_vc = (vc > 64) ? 64 : vc;
  endtask

  function automatic int pick_vertex();
    if (cur_vc == 0 || $urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(cur_vc - 1);
  endfunction

  // graph build: mostly forward edges, sometimes a back edge to close a loop
  task automatic graph_round();
    int n_add;
    int s;
    int d;
    if ($urandom_range(3) != 0) send(ACT_CLEAR, $urandom_range(63), $urandom_range(63));
    n_add = $urandom_range(1, 10);
    for (int k = 0; k < n_add; k++) begin
      s = pick_vertex();
      d = pick_vertex();
      if ($urandom_range(4) != 0 && s > d) begin
        s = s ^ d;
        d = s ^ d;
        s = s ^ d;
      end
      if ($urandom_range(29) == 0) send(ACT_NONE, $urandom_range(63), $urandom_range(63));
      send(ACT_ADD, s, d);
    end
    send(ACT_CHECK, $urandom_range(63), $urandom_range(63));
  endtask

  initial begin
    int vc_pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_CHECK, 0, 0);
    send(ACT_ADD, 63, 0);
    send(ACT_ADD, 0, 63);
    send(ACT_CHECK, 63, 63);
    send(ACT_CLEAR, 0, 0);
    send(ACT_ADD, 0, 1);
    send(ACT_ADD, 1, 2);
    send(ACT_CHECK, 0, 0);
    send(ACT_ADD, 2, 0);
    send(ACT_CHECK, 0, 0);
    send(ACT_NONE, 63, 63);
    send(ACT_CLEAR, 63, 63);
    send(ACT_ADD, 5, 5);
    send(ACT_CHECK, 0, 0);
    set_vertex_count(1);
    send(ACT_ADD, 0, 1);
    send(ACT_CHECK, 0, 0);
    set_vertex_count(0);
    send(ACT_ADD, 0, 0);
    send(ACT_CHECK, 0, 0);
    set_vertex_count(127);
    send(ACT_CLEAR, 0, 0);
    send(ACT_ADD, 42, 21);
    send(ACT_ADD, 21, 42);
    send(ACT_CHECK, 0, 0);

    // fill the edge store past capacity
    send(ACT_CLEAR, 0, 0);
    for (int k = 0; k < 260; k++) send(ACT_ADD, k % 63, k % 63 + 1);
    send(ACT_CHECK, 0, 0);
    send(ACT_ADD, 63, 0);
    send(ACT_CHECK, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 26 : 0;
      for (int r = 0; r < 3; r++) begin
        vc_pick = $urandom_range(3);
        set_vertex_count(vc_pick == 0 ? $urandom_range(1, 8) :
                         vc_pick == 1 ? 64 : $urandom_range(1, 127));
        for (int g = 0; g < 6; g++) graph_round();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_vertex_count(64);
    while (words_sent < 850) graph_round();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: directed_graph_cycle_check.f
hdl/dgcc_pkg.sv
hdl/dgcc_ram.sv
hdl/directed_graph_cycle_check.sv
tb/dgcc_result_checker.sv
tb/tb_directed_graph_cycle_check.sv
